// ----- src/hbd_pkg.sv -----
// Shared types and constants for the prefix-code bitstream decoder.
// Standalone package; every other file of the block imports it.
package hbd_pkg;

    localparam int SYM_W      = 8;
    localparam int CODE_W     = 24;
    localparam int CODE_IDX_W = $clog2(CODE_W);
    localparam int LEN_W      = 5;
    localparam int BYTE_BITS  = 8;

    localparam int NODE_COUNT_DEF   = 512;
    localparam int MAX_CODE_LEN_DEF = 24;

    localparam logic [SYM_W-1:0] END_SYMBOL = 8'd129;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [SYM_W-1:0]  entry_symbol;
        logic [CODE_W-1:0] entry_code;
        logic [LEN_W-1:0]  entry_length;
        logic [7:0]        data_byte;
    } req_item_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             end_seen;
        logic             path_error;
        logic             load_overflow;
        logic             last;
    } rsp_item_t;

    // One result as produced by the walker, before the last flag is known.
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             end_seen;
        logic             path_error;
        logic             load_overflow;
    } result_t;

    typedef struct packed {
        logic    push;
        logic    flush;
        result_t res;
    } stage_ctl_t;

    typedef struct packed {
        logic can_push;
        logic flush_ok;
    } stage_sts_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DECODE,
        ST_LOAD,
        ST_ALLOC,
        ST_DRAIN
    } walk_state_t;

    typedef enum logic [1:0] {
        SRC_ROOT,
        SRC_MEM,
        SRC_ZERO
    } node_src_t;

endpackage

// ----- src/hbd_node_mem.sv -----
// Node store of the code tree: left child, right child and symbol per node.
// One write port, one registered read port. Uses hbd_pkg.
module hbd_node_mem #(
    parameter int NODE_COUNT = hbd_pkg::NODE_COUNT_DEF,
    parameter int NODE_W     = $clog2(NODE_COUNT),
    parameter int ENT_W      = 2 * NODE_W + hbd_pkg::SYM_W
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [NODE_W-1:0] wr_addr,
    input  logic [ENT_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [NODE_W-1:0] rd_addr,
    output logic [ENT_W-1:0]  rd_data
);
    import hbd_pkg::*;

    logic [ENT_W-1:0] mem [NODE_COUNT];
    logic [ENT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/hbd_result_stage.sv -----
// Result stage: holds the newest result until it is known whether it is the
// last one of its request, then hands it to the output register. Uses hbd_pkg.
module hbd_result_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hbd_pkg::stage_ctl_t    ctl,
    output hbd_pkg::stage_sts_t    sts,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output hbd_pkg::rsp_item_t     rsp
);
    import hbd_pkg::*;

    logic      pend_valid_reg, pend_valid_next;
    result_t   pend_reg, pend_next;
    logic      out_valid_reg, out_valid_next;
    rsp_item_t out_reg, out_next;
    logic      out_free;

    assign out_free     = !out_valid_reg || rsp_ready;
    assign sts.can_push = !pend_valid_reg || out_free;
    assign sts.flush_ok = !pend_valid_reg || out_free;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        out_next        = out_reg;
        if (ctl.push && sts.can_push)
        begin
            // A newer result exists, so the held one is not the last.
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = {pend_reg, 1'b0};
            end
            pend_valid_next = 1'b1;
            pend_next       = ctl.res;
        end
        else if (ctl.flush && pend_valid_reg && out_free)
        begin
            out_valid_next  = 1'b1;
            out_next        = {pend_reg, 1'b1};
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// ----- src/hbd_walk_ctrl.sv -----
// Tree walker, uses hbd_pkg: loads code entries into the node store and decodes
// bytes bit by bit, a request at a time. Root node in flops, rest in hbd_node_mem.
module hbd_walk_ctrl #(
    parameter int NODE_COUNT   = hbd_pkg::NODE_COUNT_DEF,
    parameter int MAX_CODE_LEN = hbd_pkg::MAX_CODE_LEN_DEF,
    parameter int NODE_W       = $clog2(NODE_COUNT),
    parameter int ENT_W        = 2 * NODE_W + hbd_pkg::SYM_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  hbd_pkg::req_item_t    req,
    output logic                  mem_wr_en,
    output logic [NODE_W-1:0]     mem_wr_addr,
    output logic [ENT_W-1:0]      mem_wr_data,
    output logic                  mem_rd_en,
    output logic [NODE_W-1:0]     mem_rd_addr,
    input  logic [ENT_W-1:0]      mem_rd_data,
    output hbd_pkg::stage_ctl_t   ctl,
    input  hbd_pkg::stage_sts_t   sts
);
    import hbd_pkg::*;

    localparam int NU_W   = $clog2(NODE_COUNT + 1);
    localparam int LEN_CW = $clog2(MAX_CODE_LEN + 1);
    localparam int CNT_W  = (LEN_CW > 4) ? LEN_CW : 4;
    localparam int IDX_W  = (CNT_W > CODE_IDX_W) ? CNT_W : CODE_IDX_W;

    walk_state_t           state_reg, state_next;
    node_src_t             src_reg, src_next;
    logic                  arrive_reg, arrive_next;
    logic [NU_W-1:0]       nodes_used_reg, nodes_used_next;
    logic [NODE_W-1:0]     walk_pos_reg, walk_pos_next;
    logic                  ended_reg, ended_next;
    logic [NODE_W-1:0]     root_left_reg, root_left_next;
    logic [NODE_W-1:0]     root_right_reg, root_right_next;
    logic [SYM_W-1:0]      root_sym_reg, root_sym_next;
    logic [NODE_W-1:0]     node_reg, node_next;
    logic [CNT_W-1:0]      bits_reg, bits_next;
    logic [BYTE_BITS-1:0]  byte_sr_reg, byte_sr_next;
    logic [CODE_W-1:0]     code_reg, code_next;
    logic [SYM_W-1:0]      sym_in_reg, sym_in_next;

    logic [NODE_W-1:0]     e_left, e_right;
    logic [SYM_W-1:0]      e_sym;
    logic [IDX_W-1:0]      code_idx;
    logic                  code_bit, walk_bit;
    logic [NODE_W-1:0]     child, new_node;
    logic                  child_none, leaf, bits_done, store_full, end_hit;

    // Entry of the node the walk stands on.
    always_comb
    begin
        case (src_reg)
            SRC_ROOT:
            begin
                e_left  = root_left_reg;
                e_right = root_right_reg;
                e_sym   = root_sym_reg;
            end
            SRC_MEM:
            begin
                e_left  = mem_rd_data[ENT_W-1 -: NODE_W];
                e_right = mem_rd_data[SYM_W +: NODE_W];
                e_sym   = mem_rd_data[SYM_W-1:0];
            end
            default:
            begin
                e_left  = '0;
                e_right = '0;
                e_sym   = '0;
            end
        endcase
    end

    assign code_idx   = IDX_W'(bits_reg) - IDX_W'(1);
    assign code_bit   = (code_idx < IDX_W'(CODE_W)) ? code_reg[code_idx[CODE_IDX_W-1:0]]
                                                   : 1'b0;
    assign walk_bit   = (state_reg == ST_LOAD) ? code_bit : byte_sr_reg[BYTE_BITS-1];
    assign child      = walk_bit ? e_right : e_left;
    assign child_none = (child == '0);
    assign leaf       = (e_left == '0) || (e_right == '0);
    assign bits_done  = (bits_reg == '0);
    assign store_full = (nodes_used_reg == NU_W'(NODE_COUNT));
    assign new_node   = nodes_used_reg[NODE_W-1:0];
    assign end_hit    = (e_sym == END_SYMBOL);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.opcode == OP_LOAD)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (!ended_reg)
                    begin
                        state_next = (walk_pos_reg == '0) ? ST_DECODE : ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                if (arrive_reg && leaf)
                begin
                    if (sts.can_push && (end_hit || bits_done))
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else if (bits_done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_LOAD:
            begin
                if (bits_done || (child_none && store_full))
                begin
                    if (sts.can_push)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else if (child_none)
                begin
                    state_next = ST_ALLOC;
                end
            end
            ST_ALLOC:
            begin
                state_next = ST_LOAD;
            end
            ST_DRAIN:
            begin
                if (sts.flush_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and port controls.
    always_comb
    begin
        src_next        = src_reg;
        arrive_next     = arrive_reg;
        nodes_used_next = nodes_used_reg;
        walk_pos_next   = walk_pos_reg;
        ended_next      = ended_reg;
        root_left_next  = root_left_reg;
        root_right_next = root_right_reg;
        root_sym_next   = root_sym_reg;
        node_next       = node_reg;
        bits_next       = bits_reg;
        byte_sr_next    = byte_sr_reg;
        code_next       = code_reg;
        sym_in_next     = sym_in_reg;
        req_ready       = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = node_reg;
        mem_wr_data     = '0;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = child;
        ctl             = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req.opcode == OP_LOAD)
                    begin
                        sym_in_next = req.entry_symbol;
                        code_next   = req.entry_code;
                        if (int'(req.entry_length) > MAX_CODE_LEN)
                        begin
                            bits_next = CNT_W'(MAX_CODE_LEN);
                        end
                        else
                        begin
                            bits_next = CNT_W'(req.entry_length);
                        end
                        src_next  = SRC_ROOT;
                        node_next = '0;
                    end
                    else if (!ended_reg)
                    begin
                        byte_sr_next = req.data_byte;
                        bits_next    = CNT_W'(BYTE_BITS);
                        arrive_next  = 1'b0;
                        node_next    = walk_pos_reg;
                        src_next     = SRC_ROOT;
                        if (walk_pos_reg != '0)
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = walk_pos_reg;
                        end
                    end
                end
            end
            ST_FETCH:
            begin
                src_next = SRC_MEM;
            end
            ST_DECODE:
            begin
                if (arrive_reg && leaf)
                begin
                    // Code complete: emit and return to the root.
                    if (sts.can_push)
                    begin
                        ctl.push         = 1'b1;
                        ctl.res.symbol   = e_sym;
                        ctl.res.end_seen = end_hit;
                        src_next         = SRC_ROOT;
                        node_next        = '0;
                        arrive_next      = 1'b0;
                        walk_pos_next    = '0;
                        if (end_hit)
                        begin
                            ended_next = 1'b1;
                        end
                    end
                end
                else if (bits_done)
                begin
                    arrive_next   = 1'b0;
                    walk_pos_next = node_reg;
                end
                else if (child_none)
                begin
                    if (sts.can_push)
                    begin
                        ctl.push           = 1'b1;
                        ctl.res.path_error = 1'b1;
                        src_next           = SRC_ROOT;
                        node_next          = '0;
                        arrive_next        = 1'b0;
                        byte_sr_next       = {byte_sr_reg[BYTE_BITS-2:0], 1'b0};
                        bits_next          = bits_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    mem_rd_en    = 1'b1;
                    node_next    = child;
                    src_next     = SRC_MEM;
                    arrive_next  = 1'b1;
                    byte_sr_next = {byte_sr_reg[BYTE_BITS-2:0], 1'b0};
                    bits_next    = bits_reg - CNT_W'(1);
                end
            end
            ST_LOAD:
            begin
                if (bits_done)
                begin
                    if (sts.can_push)
                    begin
                        ctl.push = 1'b1;
                        if (node_reg == '0)
                        begin
                            root_sym_next = sym_in_reg;
                        end
                        else
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_data = {e_left, e_right, sym_in_reg};
                        end
                    end
                end
                else if (!child_none)
                begin
                    mem_rd_en = 1'b1;
                    node_next = child;
                    src_next  = SRC_MEM;
                    bits_next = bits_reg - CNT_W'(1);
                end
                else if (store_full)
                begin
                    ctl.push              = 1'b1;
                    ctl.res.load_overflow = 1'b1;
                end
                else
                begin
                    // Link a fresh node under the current one.
                    if (node_reg == '0)
                    begin
                        if (walk_bit)
                        begin
                            root_right_next = new_node;
                        end
                        else
                        begin
                            root_left_next = new_node;
                        end
                    end
                    else
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = walk_bit ? {e_left, new_node, e_sym}
                                               : {new_node, e_right, e_sym};
                    end
                    nodes_used_next = nodes_used_reg + NU_W'(1);
                    node_next       = new_node;
                end
            end
            ST_ALLOC:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = '0;
                src_next    = SRC_ZERO;
                bits_next   = bits_reg - CNT_W'(1);
            end
            ST_DRAIN:
            begin
                ctl.flush = 1'b1;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            src_reg        <= SRC_ROOT;
            arrive_reg     <= 1'b0;
            nodes_used_reg <= NU_W'(1);
            walk_pos_reg   <= '0;
            ended_reg      <= 1'b0;
            root_left_reg  <= '0;
            root_right_reg <= '0;
            root_sym_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            src_reg        <= src_next;
            arrive_reg     <= arrive_next;
            nodes_used_reg <= nodes_used_next;
            walk_pos_reg   <= walk_pos_next;
            ended_reg      <= ended_next;
            root_left_reg  <= root_left_next;
            root_right_reg <= root_right_next;
            root_sym_reg   <= root_sym_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg    <= node_next;
        bits_reg    <= bits_next;
        byte_sr_reg <= byte_sr_next;
        code_reg    <= code_next;
        sym_in_reg  <= sym_in_next;
    end

endmodule

// ----- src/huffman_bitstream_decoder_unit.sv -----
// Top level of the prefix-code bitstream decoder.
// Instantiates hbd_walk_ctrl, hbd_node_mem and hbd_result_stage; uses hbd_pkg.
//
// Usage:
//   Request channel (req_valid/req_ready/req): opcode OP_LOAD adds one code
//   entry (symbol, code, length) to the tree; OP_DECODE feeds one compressed
//   byte, consumed most significant bit first. The walk position carries
//   over between bytes, so a code may span byte boundaries.
//   Response channel (rsp_valid/rsp_ready/rsp): every load gives one result
//   carrying load_overflow. A byte gives zero to eight results: one per
//   completed code, one per bit that leaves the tree (path_error). The last
//   result of a request has last set. Terminator symbol 129 sets end_seen,
//   drops the rest of its byte and makes later bytes give no results.
// Sequence of a request:
//   One request at a time. A byte is accepted, fetches its node when the walk
//   resumes below the root, walks its bits with an emit step after each
//   completed code and an extra step when the last bit completes no code, and
//   closes out. A byte after the terminator is accepted and dropped.
//   A load walks its code path, linking and clearing a new node at each gap,
//   then stores its symbol and closes out; a load that runs out of nodes stops
//   at that point. The pace is set by the single read port of the node store.
// Reset: empties the tree (root flops cleared, node fill count back to one),
//   returns the walk to the root and clears the end-of-stream flag. No
//   clearing pass is needed: nodes are written before first use.
// Stall: a result waits in the output register; the walker keeps working
//   until it needs to hand over a second result, then holds.
module huffman_bitstream_decoder_unit #(
    parameter int NODE_COUNT   = hbd_pkg::NODE_COUNT_DEF,
    parameter int MAX_CODE_LEN = hbd_pkg::MAX_CODE_LEN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  hbd_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output hbd_pkg::rsp_item_t rsp
);
    import hbd_pkg::*;

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int ENT_W  = 2 * NODE_W + SYM_W;

    // Node store port, entry packed as {left, right, symbol}.
    logic              mem_wr_en;
    logic [NODE_W-1:0] mem_wr_addr;
    logic [ENT_W-1:0]  mem_wr_data;
    logic              mem_rd_en;
    logic [NODE_W-1:0] mem_rd_addr;
    logic [ENT_W-1:0]  mem_rd_data;

    // Walker to result stage.
    stage_ctl_t        stage_ctl;
    stage_sts_t        stage_sts;

    hbd_walk_ctrl #(
        .NODE_COUNT   (NODE_COUNT),
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .NODE_W       (NODE_W),
        .ENT_W        (ENT_W)
    ) u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .ctl         (stage_ctl),
        .sts         (stage_sts)
    );

    hbd_node_mem #(
        .NODE_COUNT (NODE_COUNT),
        .NODE_W     (NODE_W),
        .ENT_W      (ENT_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Hold the newest result until its last flag is known.
    hbd_result_stage u_res (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (stage_ctl),
        .sts       (stage_sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ----- src/hbd_checker.sv -----
// Port-level checks for the prefix-code bitstream decoder, bound to its top.
// Uses hbd_pkg.
module hbd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input hbd_pkg::req_item_t req,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input hbd_pkg::rsp_item_t rsp
);
    import hbd_pkg::*;

    // A load request keeps the walker busy, so it is not ready in the next cycle.
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.opcode == OP_LOAD) |=> !req_ready)
        else $error("request accepted right after a load");

    // The terminator closes out its request.
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.end_seen |-> rsp.last && (rsp.symbol == END_SYMBOL))
        else $error("end_seen without terminator symbol or last flag");

    // Error and overflow results carry no symbol.
    a_flag_sym: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.path_error || rsp.load_overflow) |-> (rsp.symbol == '0))
        else $error("flagged result carries a symbol");

    // A stalled response holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

endmodule

bind huffman_bitstream_decoder_unit hbd_checker u_hbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ----- bench/hbd_tb_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the prefix-code decoder bench: a private copy of the code tree
// that predicts every response, plus the queue of responses still due.
// Depends on hbd_pkg for the request and response types.
package hbd_tb_pkg;
    import hbd_pkg::*;

    localparam int NODE_W = $clog2(NODE_COUNT_DEF);

    class hbd_scoreboard;
        bit [NODE_W-1:0] left_child  [NODE_COUNT_DEF];
        bit [NODE_W-1:0] right_child [NODE_COUNT_DEF];
        bit [SYM_W-1:0]  node_symbol [NODE_COUNT_DEF];
        bit [NODE_W:0]   nodes_used;
        bit [NODE_W-1:0] walk_pos;
        bit              stream_ended;
        rsp_item_t       due_rsp [$];
        int              mismatches;
        int              checked;
        int              path_errors;
        int              terminators;
        int              overflows;

        function new();
            foreach (left_child[i])
            begin
                left_child[i]  = '0;
                right_child[i] = '0;
                node_symbol[i] = '0;
            end
            nodes_used   = 1;
            walk_pos     = '0;
            stream_ended = 1'b0;
            mismatches   = 0;
            checked      = 0;
            path_errors  = 0;
            terminators  = 0;
            overflows    = 0;
        endfunction

        // Walk the code path from the root, allocating nodes; 1 when the store ran out.
        function bit insert_code(bit [SYM_W-1:0] sym, bit [CODE_W-1:0] code,
                                 bit [LEN_W-1:0] len);
            int              depth;
            bit [NODE_W-1:0] p;
            bit [NODE_W-1:0] nxt;
            bit              dir;
            p     = '0;
            depth = (len > MAX_CODE_LEN_DEF) ? MAX_CODE_LEN_DEF : int'(len);
            for (int i = depth - 1; i >= 0; i--)
            begin
                dir = code[i];
                nxt = dir ? right_child[p] : left_child[p];
                if (nxt == 0)
                begin
                    if (nodes_used >= NODE_COUNT_DEF)
                        return 1'b1;
                    nxt = nodes_used[NODE_W-1:0];
                    nodes_used++;
                    left_child[nxt]  = '0;
                    right_child[nxt] = '0;
                    node_symbol[nxt] = '0;
                    if (dir)
                        right_child[p] = nxt;
                    else
                        left_child[p] = nxt;
                end
                p = nxt;
            end
            node_symbol[p] = sym;
            return 1'b0;
        endfunction

        function void note_request(req_item_t item);
            rsp_item_t       burst [BYTE_BITS];
            rsp_item_t       r;
            int              n;
            bit [NODE_W-1:0] p;
            bit [NODE_W-1:0] nxt;
            bit              dir;
            r = '0;
            if (item.opcode == OP_LOAD)
            begin
                r.load_overflow = insert_code(item.entry_symbol, item.entry_code,
                                              item.entry_length);
                r.last = 1'b1;
                due_rsp.push_back(r);
                return;
            end
            if (stream_ended)
                return;
            n = 0;
            p = (walk_pos >= nodes_used) ? '0 : walk_pos;
            for (int b = BYTE_BITS - 1; b >= 0; b--)
            begin
                dir = item.data_byte[b];
                nxt = dir ? right_child[p] : left_child[p];
                r   = '0;
                if (nxt == 0)
                begin
                    r.path_error = 1'b1;
                    burst[n] = r;
                    n++;
                    p = '0;
                end
                else
                begin
                    p = nxt;
                    if (left_child[p] == 0 || right_child[p] == 0)
                    begin
                        r.symbol   = node_symbol[p];
                        r.end_seen = (node_symbol[p] == END_SYMBOL);
                        burst[n] = r;
                        n++;
                        p = '0;
                        if (r.end_seen)
                        begin
                            stream_ended = 1'b1;
                            break;
                        end
                    end
                end
            end
            walk_pos = p;
            if (n > 0)
                burst[n-1].last = 1'b1;
            for (int i = 0; i < n; i++)
                due_rsp.push_back(burst[i]);
        endfunction

        function void check_field(string name, int want, int got);
            if (want != got)
            begin
                $display("%t %s mismatch: expected %0d, got %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_response(rsp_item_t got);
            rsp_item_t want;
            if (due_rsp.size() == 0)
            begin
                $display("%t response with none due: expected nothing, got %h", $time, got);
                mismatches++;
                return;
            end
            want = due_rsp.pop_front();
            checked++;
            path_errors += int'(want.path_error);
            terminators += int'(want.end_seen);
            overflows   += int'(want.load_overflow);
            check_field("symbol", int'(want.symbol), int'(got.symbol));
            check_field("end_seen", int'(want.end_seen), int'(got.end_seen));
            check_field("path_error", int'(want.path_error), int'(got.path_error));
            check_field("load_overflow", int'(want.load_overflow),
                        int'(got.load_overflow));
            check_field("last", int'(want.last), int'(got.last));
        endfunction
    endclass

endpackage

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the bench for huffman_bitstream_decoder_unit: drives code loads and
// compressed bytes, checks every response. Depends on hbd_pkg and hbd_tb_pkg.
module tb_top;
    import hbd_pkg::*;
    import hbd_tb_pkg::*;

    // A byte with the sender gaps and receiver stalls around it takes far less
    // than IDLE_LIMIT; that long with nothing moving means the block is stuck.
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_ITEMS  = 180;
    localparam int TABLE_MAX_LEN = 10;
    localparam int TABLE_LEAVES  = 22;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_item_t rsp;

    hbd_scoreboard sb;
    int            burst_left;
    bit            no_idle;
    int            idle_cycles;
    int            n_loads;
    int            n_bytes;

    huffman_bitstream_decoder_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Present one request and hold it until accepted. Called right after a
    // rising edge. After acceptance, either stay in the burst (the next call
    // overwrites the payload in the same step) or drop valid and idle.
    task automatic push_request(input req_item_t item);
        req_valid <= 1'b1;
        req       <= item;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
        sb.note_request(item);
        if (item.opcode == OP_LOAD)
            n_loads++;
        else
            n_bytes++;
        if (!no_idle)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                burst_left = $urandom_range(0, 7);
            end
        end
    endtask

    // Fields not used by an opcode carry random noise.
    task automatic send_load(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] code,
                             input logic [LEN_W-1:0] len);
        req_item_t item;
        item.opcode       = OP_LOAD;
        item.entry_symbol = sym;
        item.entry_code   = code;
        item.entry_length = len;
        item.data_byte    = 8'($urandom);
        push_request(item);
    endtask

    task automatic send_byte(input logic [7:0] data);
        req_item_t item;
        item.opcode       = OP_DECODE;
        item.entry_symbol = SYM_W'($urandom);
        item.entry_code   = CODE_W'($urandom);
        item.entry_length = LEN_W'($urandom);
        item.data_byte    = data;
        push_request(item);
    endtask

    // Any symbol but the terminator, which would end decoding for good.
    function automatic logic [SYM_W-1:0] pick_symbol();
        logic [SYM_W-1:0] sym;
        do
            sym = SYM_W'($urandom);
        while (sym == END_SYMBOL);
        return sym;
    endfunction

    task automatic run_directed();
        send_byte(8'hA5);                   // empty tree: every bit leaves it
        send_load(8'h41, 24'h000000, 1);    // "0"
        send_byte(8'h0F);                   // four symbols, four path errors
        send_load(8'h55, 24'hFFFFFF, 0);    // zero length lands on the root
        send_load(8'hFF, 24'h000002, 2);    // "10": node "1" has one child only
        send_byte(8'hC0);                   // single-child node ends a code
        send_load(8'h00, 24'h000003, 2);    // "11"
        send_byte(8'hB6);
        send_byte(8'h01);                   // seven results, walk parked below root
        send_byte(8'h80);                   // resume from the parked node
        send_load(8'h7E, 24'hFFFFFF, 31);   // overlong, saturates
        send_load(8'h01, 24'h000000, 24);   // longest all-zero path
        send_load(8'h80, 24'hABCDEF, 24);
        send_load(8'h3C, 24'h123456, 25);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_load(8'hC3, 24'h000001, 1);    // overwrite an inner node's symbol
        send_load(8'hAA, 24'h000001, 2);    // "01"
        send_byte(8'h5A);
        send_byte(8'h00);
    endtask

    // Load a complete prefix code, then mostly decode random bytes against it,
    // mixed with loads that reuse, extend or break the table.
    task automatic run_random();
        logic [CODE_W-1:0] tcode [$];
        int                tlen [$];
        logic [CODE_W-1:0] c;
        int                l;
        int                k;
        int                tries;
        tcode.push_back('0);
        tlen.push_back(0);
        tries = 0;
        // Deepen one branch first so some codes span a whole byte, then
        // split leaves at random until the table is big enough.
        while (tcode.size() < TABLE_LEAVES && tries < 400)
        begin
            k = (tries < TABLE_MAX_LEN) ? 0 : $urandom_range(0, tcode.size() - 1);
            tries++;
            if (tlen[k] < TABLE_MAX_LEN)
            begin
                c = tcode[k];
                l = tlen[k];
                tcode[k] = {c[CODE_W-2:0], 1'b0};
                tlen[k]  = l + 1;
                tcode.push_back({c[CODE_W-2:0], 1'b1});
                tlen.push_back(l + 1);
            end
        end
        foreach (tcode[i])
            send_load(pick_symbol(), tcode[i], LEN_W'(tlen[i]));
        send_byte(8'h00);
        send_byte(8'h00);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Hold both sides busy for one stretch.
            no_idle = (n >= 80 && n < 120);
            k = $urandom_range(0, 99);
            if (k < 75)
                send_byte(8'($urandom));
            else if (k < 87)
            begin
                l = $urandom_range(0, tcode.size() - 1);
                send_load(pick_symbol(), tcode[l], LEN_W'(tlen[l]));
            end
            else if (k < 94)
                send_load(pick_symbol(), CODE_W'($urandom), LEN_W'($urandom_range(1, 8)));
            else if (k < 97)
                send_load(pick_symbol(), CODE_W'($urandom), 24);
            else
                send_load(pick_symbol(), CODE_W'($urandom),
                          LEN_W'($urandom_range(0, 1) ? 0 : $urandom_range(25, 31)));
        end
        no_idle = 1'b0;
    endtask

    // Plant the terminator on a reachable leaf, decode until it fires, then
    // show that bytes are dropped while loads still answer.
    task automatic run_end_of_stream();
        logic [NODE_W-1:0] p;
        logic [NODE_W-1:0] nxt;
        logic [CODE_W-1:0] c;
        int                l;
        int                tries;
        bit                dir;
        p = '0;
        c = '0;
        l = 0;
        forever
        begin
            dir = 1'($urandom_range(0, 1));
            nxt = dir ? sb.right_child[p] : sb.left_child[p];
            if (nxt == 0)
            begin
                dir = !dir;
                nxt = dir ? sb.right_child[p] : sb.left_child[p];
            end
            if (nxt == 0 || l == MAX_CODE_LEN_DEF)
                break;
            p = nxt;
            c = {c[CODE_W-2:0], dir};
            l++;
            if (sb.left_child[p] == 0 || sb.right_child[p] == 0)
                break;
        end
        send_load(END_SYMBOL, c, LEN_W'(l));
        tries = 0;
        while (!sb.stream_ended && tries < 64)
        begin
            send_byte(8'($urandom));
            tries++;
        end
        repeat (4) send_byte(8'($urandom));
        send_load(pick_symbol(), CODE_W'($urandom), LEN_W'($urandom_range(1, 6)));
    endtask

    // Fill the node store with long random codes until it runs out.
    task automatic run_node_exhaustion();
        int tries;
        tries = 0;
        while (sb.nodes_used < NODE_COUNT_DEF && tries < 80)
        begin
            send_load(pick_symbol(), CODE_W'($urandom), 24);
            tries++;
        end
        send_load(pick_symbol(), CODE_W'($urandom), 24);
        send_load(pick_symbol(), CODE_W'($urandom), 31);
        send_load(pick_symbol(), 24'h000000, 0);    // no allocation needed
        send_byte(8'($urandom));
    endtask

    initial
    begin
        sb         = new();
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        burst_left = 0;
        no_idle    = 1'b0;
        n_loads    = 0;
        n_bytes    = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random();
        run_end_of_stream();
        run_node_exhaustion();
        req_valid <= 1'b0;

        // Drain what is still due, then give stray responses time to show.
        while (sb.due_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d code loads and %0d compressed bytes; %0d responses checked.",
                 n_loads, n_bytes, sb.checked);
        $display("Seen %0d path errors, %0d terminator(s), %0d node-store overflows.",
                 sb.path_errors, sb.terminators, sb.overflows);
        if (sb.mismatches == 0 && sb.due_rsp.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Response side: check each accepted response, then pick the next ready
    // level. Alternate ready runs and stall runs of random length.
    initial
    begin
        int hold;
        rsp_ready <= 1'b0;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                sb.check_response(rsp);
            if (no_idle)
                rsp_ready <= 1'b1;
            else if (hold > 0)
                hold--;
            else
            begin
                rsp_ready <= !rsp_ready;
                // rsp_ready still holds the old level here: 1 means a stall starts.
                hold = rsp_ready ? $urandom_range(0, 5) : $urandom_range(0, 11);
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a request or response.
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%t nothing moved for %0d cycles, %0d responses still due",
                 $time, IDLE_LIMIT, sb.due_rsp.size());
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
